// ----- design/nnr_pkg.sv -----
package nnr_pkg;

	// fixed field widths
	localparam int CW       = 12;
	localparam int SAMPLE_W = 8;
	localparam int CHAN_W   = 2;
	localparam int CNT_W    = 3;
	localparam int SRC_W    = 8;

	// default frame limits
	localparam int DEF_MAX_WIDTH    = 128;
	localparam int DEF_MAX_HEIGHT   = 128;
	localparam int DEF_MAX_CHANNELS = 4;

	// queue between front and back, power of two
	localparam int FIFO_DEPTH = 4;

	// register port
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	localparam logic [SRC_W-1:0] RST_SRC_WIDTH     = 8'd128;
	localparam logic [SRC_W-1:0] RST_SRC_HEIGHT    = 8'd128;
	localparam logic [CNT_W-1:0] RST_CHANNEL_COUNT = 3'd3;
	localparam logic [CW-1:0]    RST_DST_WIDTH     = 12'd0;
	localparam logic [CW-1:0]    RST_DST_HEIGHT    = 12'd0;

	typedef enum logic [2:0] {
		REG_SRC_WIDTH     = 3'd0,
		REG_SRC_HEIGHT    = 3'd1,
		REG_CHANNEL_COUNT = 3'd2,
		REG_DST_WIDTH     = 3'd3,
		REG_DST_HEIGHT    = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_BAD   = 2'd2
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [SAMPLE_W-1:0] sample;
	} item_ctl_t;

endpackage

// ----- design/nnr_div.sv -----
module nnr_div import nnr_pkg::*; #(
	parameter int DVW = 20,
	parameter int DSW = 12,
	parameter int QW  = 7
) (
	input  logic           clk,
	input  logic           en,
	input  logic [DVW-1:0] dividend,
	input  logic [DSW-1:0] divisor,
	output logic [QW-1:0]  quotient
);

	// restoring division, one quotient bit per stage, msb first
	localparam int CMW = DVW + DSW + QW;

	logic [DVW-1:0] rem_s [QW];
	logic [QW-1:0]  quo_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [CMW-1:0] rin;
		logic [QW-1:0]  qin;
		logic [CMW-1:0] dsh;
		logic           ge;

		if (k == 0) begin : g_first
			assign rin = CMW'(dividend);
			assign qin = '0;
		end else begin : g_next
			assign rin = CMW'(rem_s[k-1]);
			assign qin = quo_s[k-1];
		end

		assign dsh = CMW'(divisor) << (QW - 1 - k);
		assign ge  = (rin >= dsh);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DVW'(rin - dsh) : DVW'(rin);
				quo_s[k] <= qin | (QW'(ge) << (QW - 1 - k));
			end
		end
	end

	assign quotient = quo_s[QW-1];

endmodule

// ----- design/nnr_front.sv -----
module nnr_front import nnr_pkg::*; #(
	parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                kind,
	input  logic [CW-1:0]       col,
	input  logic [CW-1:0]       row,
	input  logic [CHAN_W-1:0]   chan,
	input  logic [SAMPLE_W-1:0] sample_in,
	input  logic [SRC_W-1:0]    src_width,
	input  logic [SRC_W-1:0]    src_height,
	input  logic [CNT_W-1:0]    channel_count,
	input  logic [CW-1:0]       dst_width,
	input  logic [CW-1:0]       dst_height,
	input  logic                full,
	output logic                push,
	output item_ctl_t           push_ctl,
	output logic [$clog2(MAX_WIDTH*MAX_HEIGHT*MAX_CHANNELS > 1 ?
		MAX_WIDTH*MAX_HEIGHT*MAX_CHANNELS : 2)-1:0] push_addr
);

	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
	localparam int AW     = $clog2(DEPTH > 1 ? DEPTH : 2);
	localparam int XW     = $clog2(MAX_WIDTH > 1 ? MAX_WIDTH : 2);
	localparam int YW     = $clog2(MAX_HEIGHT > 1 ? MAX_HEIGHT : 2);
	localparam int SW_W   = $clog2(MAX_WIDTH + 1);
	localparam int SH_W   = $clog2(MAX_HEIGHT + 1);
	localparam int PXW    = CW + SW_W;
	localparam int PYW    = CW + SH_W;
	localparam int STAGES = (XW > YW) ? XW : YW;

	typedef struct packed {
		op_t                 op;
		logic                direct;
		logic [XW-1:0]       x;
		logic [YW-1:0]       y;
		logic [CHAN_W-1:0]   chan;
		logic [SAMPLE_W-1:0] sample;
	} sb_t;

	// effective frame sizes
	logic [SW_W-1:0]  sw;
	logic [SH_W-1:0]  sh;
	logic [CNT_W-1:0] nc;
	logic             identity;
	logic [CW:0]      ow;
	logic [CW:0]      oh;

	always_comb begin
		if (src_width == '0)
			sw = SW_W'(1);
		else if (int'(src_width) > MAX_WIDTH)
			sw = SW_W'(MAX_WIDTH);
		else
			sw = SW_W'(src_width);
		if (src_height == '0)
			sh = SH_W'(1);
		else if (int'(src_height) > MAX_HEIGHT)
			sh = SH_W'(MAX_HEIGHT);
		else
			sh = SH_W'(src_height);
		if (channel_count == '0)
			nc = CNT_W'(1);
		else if (int'(channel_count) > MAX_CHANNELS)
			nc = CNT_W'(MAX_CHANNELS);
		else
			nc = channel_count;
		identity = (dst_width == '0) || (dst_height == '0);
		ow = identity ? (CW+1)'(sw) : {1'b0, dst_width};
		oh = identity ? (CW+1)'(sh) : {1'b0, dst_height};
	end

	// sideband pipeline alongside the dividers
	logic sbv_s [STAGES];
	sb_t  sb_s  [STAGES];

	logic en;
	logic last_v;

	assign last_v   = sbv_s[STAGES-1];
	assign en       = !(last_v && full);
	assign in_ready = en;

	// input register
	logic                v_s1;
	logic                kind_s1;
	logic [CW-1:0]       col_s1;
	logic [CW-1:0]       row_s1;
	logic [CHAN_W-1:0]   chan_s1;
	logic [SAMPLE_W-1:0] samp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= kind;
			col_s1  <= col;
			row_s1  <= row;
			chan_s1 <= chan;
			samp_s1 <= sample_in;
		end
	end

	// classify and scale
	logic src_in;
	logic dst_in;
	logic drop;
	op_t  op_c;

	always_comb begin
		src_in = ({1'b0, col_s1} < (CW+1)'(sw)) && ({1'b0, row_s1} < (CW+1)'(sh)) &&
			({1'b0, chan_s1} < nc);
		dst_in = ({1'b0, col_s1} < ow) && ({1'b0, row_s1} < oh) && ({1'b0, chan_s1} < nc);
		drop   = !kind_s1 && !src_in;
		if (!kind_s1)
			op_c = OP_WRITE;
		else if (dst_in)
			op_c = OP_READ;
		else
			op_c = OP_BAD;
	end

	logic           v_s2;
	sb_t            sb_s2;
	logic [PXW-1:0] px_s2;
	logic [PYW-1:0] py_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1 && !drop;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s2.op     <= op_c;
			sb_s2.direct <= !kind_s1 || identity;
			sb_s2.x      <= XW'(col_s1);
			sb_s2.y      <= YW'(row_s1);
			sb_s2.chan   <= chan_s1;
			sb_s2.sample <= samp_s1;
			px_s2        <= PXW'(col_s1) * PXW'(sw);
			py_s2        <= PYW'(row_s1) * PYW'(sh);
		end
	end

	// divider pipelines, sideband travels alongside
	logic [STAGES-1:0] qx;
	logic [STAGES-1:0] qy;

	nnr_div #(.DVW(PXW), .DSW(CW), .QW(STAGES)) u_div_x (
		.clk      (clk),
		.en       (en),
		.dividend (px_s2),
		.divisor  (dst_width),
		.quotient (qx)
	);

	nnr_div #(.DVW(PYW), .DSW(CW), .QW(STAGES)) u_div_y (
		.clk      (clk),
		.en       (en),
		.dividend (py_s2),
		.divisor  (dst_height),
		.quotient (qy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < STAGES; k++)
				sbv_s[k] <= 1'b0;
		end else if (en) begin
			sbv_s[0] <= v_s2;
			for (int k = 1; k < STAGES; k++)
				sbv_s[k] <= sbv_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s[0] <= sb_s2;
			for (int k = 1; k < STAGES; k++)
				sb_s[k] <= sb_s[k-1];
		end
	end

	// clamp and form the store address
	logic [XW-1:0] sx;
	logic [YW-1:0] sy;
	sb_t           last;

	always_comb begin
		last = sb_s[STAGES-1];
		if (last.direct)
			sx = last.x;
		else if (int'(qx) >= int'(sw))
			sx = XW'(sw - SW_W'(1));
		else
			sx = XW'(qx);
		if (last.direct)
			sy = last.y;
		else if (int'(qy) >= int'(sh))
			sy = YW'(sh - SH_W'(1));
		else
			sy = YW'(qy);
	end

	assign push            = last_v && en;
	assign push_ctl.op     = last.op;
	assign push_ctl.sample = last.sample;
	assign push_addr       = AW'((int'(sy) * MAX_WIDTH + int'(sx)) * MAX_CHANNELS +
		int'(last.chan));

endmodule

// ----- design/nnr_fifo.sv -----
module nnr_fifo import nnr_pkg::*; #(
	parameter int AW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  item_ctl_t     push_ctl,
	input  logic [AW-1:0] push_addr,
	input  logic          pop,
	output logic          full,
	output logic          empty,
	output item_ctl_t     head_ctl,
	output logic [AW-1:0] head_addr
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	item_ctl_t        ctl_q  [FIFO_DEPTH];
	logic [AW-1:0]    addr_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(FIFO_DEPTH));
	assign empty     = (count_q == '0);
	assign head_ctl  = ctl_q[rd_ptr_q];
	assign head_addr = addr_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ctl_q[wr_ptr_q]  <= push_ctl;
			addr_q[wr_ptr_q] <= push_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= PTR_W'(wr_ptr_q + 1'b1);
			if (pop)
				rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
			case ({push, pop})
				2'b10:   count_q <= CNT_W'(count_q + 1'b1);
				2'b01:   count_q <= CNT_W'(count_q - 1'b1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- design/nnr_back.sv -----
module nnr_back import nnr_pkg::*; #(
	parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                empty,
	input  item_ctl_t           head_ctl,
	input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT*MAX_CHANNELS > 1 ?
		MAX_WIDTH*MAX_HEIGHT*MAX_CHANNELS : 2)-1:0] head_addr,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SAMPLE_W-1:0] sample_out,
	output logic                bad_coordinate
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;

	logic [SAMPLE_W-1:0] store [DEPTH];
	logic [SAMPLE_W-1:0] rdata_q;
	logic                out_valid_q;
	logic                bad_q;
	logic                is_write;
	logic                is_read;

	assign pop = !empty && (!out_valid_q || out_ready);

	always_comb begin
		is_write = 1'b0;
		is_read  = 1'b0;
		unique case (head_ctl.op)
			OP_WRITE: is_write = 1'b1;
			OP_READ:  is_read  = 1'b1;
			default:  ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop && is_write)
			store[head_addr] <= head_ctl.sample;
		if (pop && is_read)
			rdata_q <= store[head_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			bad_q       <= 1'b0;
		end else if (pop) begin
			out_valid_q <= !is_write;
			bad_q       <= !is_write && !is_read;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign bad_coordinate = bad_q;
	assign sample_out     = bad_q ? '0 : rdata_q;

endmodule

// ----- design/nearest_neighbor_image_resize_unit.sv -----
// channel   direction  handshake                       payload
// in        input      in_valid / in_ready             kind, col, row, chan, sample_in
// out       output     out_valid / out_ready           sample_out, bad_coordinate
// config    input      psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// one item per clock sustained while the output does not stall; a fetch passes the input
// register, the scale register, the divider pipeline, the queue and the output register,
// and the divider pipeline resolves one quotient bit per stage
// reset clears control and registers only; the frame store is not cleared, a sample reads
// back only after it was loaded
// a stall on the output fills the queue, then freezes the front pipeline and drops in_ready
module nearest_neighbor_image_resize_unit import nnr_pkg::*; #(
	parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
	input  logic                clk,
	input  logic                arst_n,
	// input items
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                kind,
	input  logic [CW-1:0]       col,
	input  logic [CW-1:0]       row,
	input  logic [CHAN_W-1:0]   chan,
	input  logic [SAMPLE_W-1:0] sample_in,
	// result items
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SAMPLE_W-1:0] sample_out,
	output logic                bad_coordinate,
	// register port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
	localparam int AW    = $clog2(DEPTH > 1 ? DEPTH : 2);

	// configuration registers, to be written only while idle; the block does not enforce it
	logic [SRC_W-1:0] src_width_q;
	logic [SRC_W-1:0] src_height_q;
	logic [CNT_W-1:0] channel_count_q;
	logic [CW-1:0]    dst_width_q;
	logic [CW-1:0]    dst_height_q;
	logic             wr_en;
	reg_idx_t         reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	// word addressed, byte offset bits ignored
	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q     <= RST_SRC_WIDTH;
			src_height_q    <= RST_SRC_HEIGHT;
			channel_count_q <= RST_CHANNEL_COUNT;
			dst_width_q     <= RST_DST_WIDTH;
			dst_height_q    <= RST_DST_HEIGHT;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SRC_WIDTH:     src_width_q     <= pwdata[SRC_W-1:0];
				REG_SRC_HEIGHT:    src_height_q    <= pwdata[SRC_W-1:0];
				REG_CHANNEL_COUNT: channel_count_q <= pwdata[CNT_W-1:0];
				REG_DST_WIDTH:     dst_width_q     <= pwdata[CW-1:0];
				REG_DST_HEIGHT:    dst_height_q    <= pwdata[CW-1:0];
				default:           ;
			endcase
		end
	end

	// read back, unmapped addresses return zero
	always_comb begin
		unique case (reg_idx)
			REG_SRC_WIDTH:     prdata = PDATA_W'(src_width_q);
			REG_SRC_HEIGHT:    prdata = PDATA_W'(src_height_q);
			REG_CHANNEL_COUNT: prdata = PDATA_W'(channel_count_q);
			REG_DST_WIDTH:     prdata = PDATA_W'(dst_width_q);
			REG_DST_HEIGHT:    prdata = PDATA_W'(dst_height_q);
			default:           prdata = '0;
		endcase
	end

	// front: accept, classify, scale coordinates, form store address
	logic          push;
	item_ctl_t     push_ctl;
	logic [AW-1:0] push_addr;
	logic          full;

	nnr_front #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_HEIGHT   (MAX_HEIGHT),
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (kind),
		.col           (col),
		.row           (row),
		.chan          (chan),
		.sample_in     (sample_in),
		.src_width     (src_width_q),
		.src_height    (src_height_q),
		.channel_count (channel_count_q),
		.dst_width     (dst_width_q),
		.dst_height    (dst_height_q),
		.full          (full),
		.push          (push),
		.push_ctl      (push_ctl),
		.push_addr     (push_addr)
	);

	// queue keeps loads and fetches in order between front and back
	logic          pop;
	logic          empty;
	item_ctl_t     head_ctl;
	logic [AW-1:0] head_addr;

	nnr_fifo #(.AW(AW)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_ctl  (push_ctl),
		.push_addr (push_addr),
		.pop       (pop),
		.full      (full),
		.empty     (empty),
		.head_ctl  (head_ctl),
		.head_addr (head_addr)
	);

	// back: frame store access and output register
	nnr_back #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_HEIGHT   (MAX_HEIGHT),
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.empty          (empty),
		.head_ctl       (head_ctl),
		.head_addr      (head_addr),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.sample_out     (sample_out),
		.bad_coordinate (bad_coordinate)
	);

endmodule

// ----- tb/sv/nnr_tb_pkg.sv -----
`timescale 1ns / 100ps

package nnr_tb_pkg;
	import nnr_pkg::*;

	typedef enum logic {
		KIND_LOAD  = 1'b0,
		KIND_FETCH = 1'b1
	} kind_e;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                bad;
	} fetch_result_t;

	// register values outside the legal range act as the nearest bound
	function automatic int unsigned clamp_size(input int unsigned raw, input int unsigned limit);
		if (raw == 0)
			return 1;
		if (raw > limit)
			return limit;
		return raw;
	endfunction

endpackage

// ----- tb/sv/nnr_fetch_checker.sv -----
`timescale 1ns / 100ps

module nnr_fetch_checker import nnr_pkg::*; import nnr_tb_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic                kind,
	input  logic [CW-1:0]       col,
	input  logic [CW-1:0]       row,
	input  logic [CHAN_W-1:0]   chan,
	input  logic [SAMPLE_W-1:0] sample_in,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [SAMPLE_W-1:0] sample_out,
	input  logic                bad_coordinate,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	input  logic [PDATA_W-1:0]  prdata,
	input  logic                pready,
	output int                  fail_count,
	output int                  pending,
	output int                  loads_seen,
	output int                  fetches_seen,
	output int                  bad_seen
);

	localparam int STORE_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT * DEF_MAX_CHANNELS;

	logic [SRC_W-1:0]    src_width_q;
	logic [SRC_W-1:0]    src_height_q;
	logic [CNT_W-1:0]    chan_count_q;
	logic [CW-1:0]       dst_width_q;
	logic [CW-1:0]       dst_height_q;
	logic [SAMPLE_W-1:0] frame_copy [0:STORE_DEPTH-1];
	fetch_result_t       awaited_samples [$];

	function automatic int unsigned store_index(input int unsigned x, input int unsigned y,
			input int unsigned c);
		return (y * DEF_MAX_WIDTH + x) * DEF_MAX_CHANNELS + c;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		int unsigned         sw, sh, nc, ow, oh, sx, sy;
		logic                identity;
		fetch_result_t       want;
		logic [PDATA_W-1:0]  shown;
		logic                known;
		if (!arst_n) begin
			src_width_q  = RST_SRC_WIDTH;
			src_height_q = RST_SRC_HEIGHT;
			chan_count_q = RST_CHANNEL_COUNT;
			dst_width_q  = RST_DST_WIDTH;
			dst_height_q = RST_DST_HEIGHT;
			awaited_samples.delete();
			fail_count   = 0;
			pending      = 0;
			loads_seen   = 0;
			fetches_seen = 0;
			bad_seen     = 0;
		end else begin
			// results leaving the block, oldest expectation first
			if (out_valid && out_ready) begin
				if (awaited_samples.size() == 0) begin
					$error("sample_out: no fetch waiting, got 0x%02h (bad_coordinate %0b)",
						sample_out, bad_coordinate);
					fail_count++;
				end else begin
					want = awaited_samples.pop_front();
					if (sample_out !== want.sample) begin
						$error("sample_out: expected 0x%02h, got 0x%02h", want.sample, sample_out);
						fail_count++;
					end
					if (bad_coordinate !== want.bad) begin
						$error("bad_coordinate: expected %0b, got %0b", want.bad, bad_coordinate);
						fail_count++;
					end
				end
			end

			// register port
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[PADDR_W-1:2])
						REG_SRC_WIDTH:     src_width_q  = pwdata[SRC_W-1:0];
						REG_SRC_HEIGHT:    src_height_q = pwdata[SRC_W-1:0];
						REG_CHANNEL_COUNT: chan_count_q = pwdata[CNT_W-1:0];
						REG_DST_WIDTH:     dst_width_q  = pwdata[CW-1:0];
						REG_DST_HEIGHT:    dst_height_q = pwdata[CW-1:0];
						default: ;
					endcase
				end else begin
					known = 1'b1;
					shown = '0;
					case (paddr[PADDR_W-1:2])
						REG_SRC_WIDTH:     shown = PDATA_W'(src_width_q);
						REG_SRC_HEIGHT:    shown = PDATA_W'(src_height_q);
						REG_CHANNEL_COUNT: shown = PDATA_W'(chan_count_q);
						REG_DST_WIDTH:     shown = PDATA_W'(dst_width_q);
						REG_DST_HEIGHT:    shown = PDATA_W'(dst_height_q);
						default:           known = 1'b0;
					endcase
					if (known && prdata !== shown) begin
						$error("prdata (paddr 0x%02h): expected 0x%08h, got 0x%08h",
							paddr, shown, prdata);
						fail_count++;
					end
				end
			end

			// items entering the block
			if (in_valid && in_ready) begin
				sw = clamp_size(src_width_q, DEF_MAX_WIDTH);
				sh = clamp_size(src_height_q, DEF_MAX_HEIGHT);
				nc = clamp_size(chan_count_q, DEF_MAX_CHANNELS);
				identity = (dst_width_q == 0) || (dst_height_q == 0);
				ow = identity ? sw : dst_width_q;
				oh = identity ? sh : dst_height_q;
				if (kind == KIND_LOAD) begin
					loads_seen++;
					if (col < sw && row < sh && chan < nc)
						frame_copy[store_index(col, row, chan)] = sample_in;
				end else begin
					fetches_seen++;
					if (col >= ow || row >= oh || chan >= nc) begin
						bad_seen++;
						want.sample = '0;
						want.bad    = 1'b1;
					end else begin
						if (identity) begin
							sx = col;
							sy = row;
						end else begin
							sx = (col * sw) / dst_width_q;
							sy = (row * sh) / dst_height_q;
							if (sx >= sw)
								sx = sw - 1;
							if (sy >= sh)
								sy = sh - 1;
						end
						want.sample = frame_copy[store_index(sx, sy, chan)];
						want.bad    = 1'b0;
					end
					awaited_samples.push_back(want);
				end
			end

			pending = awaited_samples.size();
		end
	end

endmodule

// ----- tb/sv/tb_nearest_neighbor_image_resize_unit.sv -----
`timescale 1ns / 100ps

module tb_nearest_neighbor_image_resize_unit;
	import nnr_pkg::*;
	import nnr_tb_pkg::*;

	localparam int CLK_PERIOD     = 4;
	localparam int ITEM_TARGET    = 950;
	// pipeline depth plus the output queue, with margin, for loads still in flight
	localparam int SETTLE_CYCLES  = 24;
	localparam int LONG_HOLD      = 150;
	// longest legal quiet stretch is the long hold plus a drain, so this is generous
	localparam int WATCHDOG_LIMIT = 3000;
	// register indexes the block does not decode
	localparam logic [2:0] REG_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] REG_UNUSED_LAST  = 3'd7;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic                kind;
	logic [CW-1:0]       col;
	logic [CW-1:0]       row;
	logic [CHAN_W-1:0]   chan;
	logic [SAMPLE_W-1:0] sample_in;
	logic                out_valid;
	logic                out_ready;
	logic [SAMPLE_W-1:0] sample_out;
	logic                bad_coordinate;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	int fail_count, pending, loads_seen, fetches_seen, bad_seen;

	// stimulus bookkeeping: effective frame sizes of the current setting
	int unsigned eff_sw, eff_sh, eff_nc, out_w, out_h;
	int          items_sent;
	int          burst_left;
	int          settings_count;
	int          quiet_cycles;
	bit          long_hold_req;

	always #(CLK_PERIOD / 2) clk = ~clk;

	nearest_neighbor_image_resize_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.col            (col),
		.row            (row),
		.chan           (chan),
		.sample_in      (sample_in),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.sample_out     (sample_out),
		.bad_coordinate (bad_coordinate),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	nnr_fetch_checker fetch_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.col            (col),
		.row            (row),
		.chan           (chan),
		.sample_in      (sample_in),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.sample_out     (sample_out),
		.bad_coordinate (bad_coordinate),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.fail_count     (fail_count),
		.pending        (pending),
		.loads_seen     (loads_seen),
		.fetches_seen   (fetches_seen),
		.bad_seen       (bad_seen)
	);

	// offer one item, starting at a falling edge; returns at the falling edge after
	// acceptance with valid still high, so the next item can follow without a bubble
	task automatic offer_item(input logic k, input int unsigned c, input int unsigned r,
			input int unsigned ch, input int unsigned s);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			// a third of the bursts follow the previous one back to back
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid  <= 1'b1;
		kind      <= k;
		col       <= c[CW-1:0];
		row       <= r[CW-1:0];
		chan      <= ch[CHAN_W-1:0];
		sample_in <= s[SAMPLE_W-1:0];
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		items_sent++;
	endtask

	// drop valid, wait for every fetch to answer, then let any trailing load drain
	task automatic settle();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		burst_left = 0;
	endtask

	// one register port transfer: setup phase, then access until pready
	task automatic reg_access(input logic write, input logic [2:0] idx,
			input logic [PDATA_W-1:0] word);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= {idx, 2'b00};
		pwdata  <= word;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
	endtask

	// write all five registers (upper bits of the bus word are junk), poke an
	// undecoded index, read everything back, and note the effective frame sizes
	task automatic program_frame(input int unsigned sw_raw, input int unsigned sh_raw,
			input int unsigned nc_raw, input int unsigned dw, input int unsigned dh);
		logic [PDATA_W-1:0] word;
		word = $urandom;
		word[SRC_W-1:0] = sw_raw[SRC_W-1:0];
		reg_access(1'b1, REG_SRC_WIDTH, word);
		word = $urandom;
		word[SRC_W-1:0] = sh_raw[SRC_W-1:0];
		reg_access(1'b1, REG_SRC_HEIGHT, word);
		word = $urandom;
		word[CNT_W-1:0] = nc_raw[CNT_W-1:0];
		reg_access(1'b1, REG_CHANNEL_COUNT, word);
		word = $urandom;
		word[CW-1:0] = dw[CW-1:0];
		reg_access(1'b1, REG_DST_WIDTH, word);
		word = $urandom;
		word[CW-1:0] = dh[CW-1:0];
		reg_access(1'b1, REG_DST_HEIGHT, word);
		reg_access(1'b1, 3'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)), $urandom);
		for (int i = REG_SRC_WIDTH; i <= REG_DST_HEIGHT; i++)
			reg_access(1'b0, i[2:0], '0);
		psel    <= 1'b0;
		penable <= 1'b0;
		eff_sw = clamp_size(sw_raw[SRC_W-1:0], DEF_MAX_WIDTH);
		eff_sh = clamp_size(sh_raw[SRC_W-1:0], DEF_MAX_HEIGHT);
		eff_nc = clamp_size(nc_raw[CNT_W-1:0], DEF_MAX_CHANNELS);
		// a zero on either output axis means the source frame is passed through
		if (dw[CW-1:0] == 0 || dh[CW-1:0] == 0) begin
			out_w = eff_sw;
			out_h = eff_sh;
		end else begin
			out_w = dw[CW-1:0];
			out_h = dh[CW-1:0];
		end
		settings_count++;
	endtask

	// output frame size: identity, the extreme, tiny downscales/upscales, or anything
	function automatic int unsigned random_out_size();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 2)
			return 0;
		if (pick == 2)
			return 4095;
		if (pick < 7)
			return $urandom_range(1, 12);
		return $urandom_range(1, 4095);
	endfunction

	// receiver: ready pattern is picked at random for each random span; on request it holds
	// off for a long stretch so the queue fills and the input backs up
	initial begin
		int mode;
		int span;
		int tick;
		out_ready = 1'b0;
		span = 0;
		tick = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				long_hold_req = 1'b0;
			end
			if (span == 0) begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(20, 120);
			end
			span--;
			tick++;
			case (mode)
				0:       out_ready <= 1'b1;
				1:       out_ready <= ($urandom_range(0, 1) != 0);
				2:       out_ready <= ($urandom_range(0, 3) != 0);
				default: out_ready <= (tick % 4 == 0);
			endcase
		end
	end

	// watchdog: any handshake on any port counts as progress
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (psel && penable && pready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("no handshake for %0d cycles, %0d results outstanding",
				quiet_cycles, pending);
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int unsigned pick;
		int unsigned sw_raw, sh_raw, nc_raw;
		int          body_items;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		kind           = KIND_LOAD;
		col            = '0;
		row            = '0;
		chan           = '0;
		sample_in      = '0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		items_sent     = 0;
		burst_left     = 0;
		settings_count = 0;
		quiet_cycles   = 0;
		long_hold_req  = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset setting is 128x128, three channels, identity; nothing is loaded yet,
		// so only fetches that fall outside the frame are legal here
		offer_item(KIND_FETCH, 200, 0, 0, 8'h00);   // column past the source width
		offer_item(KIND_FETCH, 0, 0, 3, 8'hFF);     // channel equal to the count
		offer_item(KIND_FETCH, 4095, 4095, 3, 8'h00);
		settle();

		// 2x2 single channel, identity
		program_frame(2, 2, 1, 0, 0);
		offer_item(KIND_LOAD, 0, 0, 0, 8'h00);
		offer_item(KIND_LOAD, 1, 0, 0, 8'hFF);
		offer_item(KIND_LOAD, 0, 1, 0, 8'hA5);
		offer_item(KIND_LOAD, 1, 1, 0, 8'h5A);
		offer_item(KIND_LOAD, 4095, 4095, 3, 8'h33); // out of frame on every axis, dropped
		offer_item(KIND_LOAD, 0, 0, 1, 8'h77);       // channel beyond the count, dropped
		offer_item(KIND_FETCH, 1, 1, 0, 8'hFF);
		offer_item(KIND_FETCH, 0, 0, 0, 8'hFF);      // must still read the first load
		offer_item(KIND_FETCH, 1, 0, 0, 8'h00);
		offer_item(KIND_FETCH, 2, 0, 0, 8'h00);      // past the identity frame
		settle();

		// largest output frame: every output pixel maps back into 2x2
		program_frame(2, 2, 1, 4095, 4095);
		offer_item(KIND_FETCH, 4094, 4094, 0, 8'h00);
		offer_item(KIND_FETCH, 2047, 2048, 0, 8'hFF);
		offer_item(KIND_FETCH, 4095, 0, 0, 8'h00);
		offer_item(KIND_FETCH, 0, 4095, 0, 8'h00);
		settle();

		// only one output axis zero still means identity
		program_frame(2, 2, 1, 4095, 0);
		offer_item(KIND_FETCH, 1, 1, 0, 8'h00);
		offer_item(KIND_FETCH, 0, 2, 0, 8'h00);
		settle();

		// random settings: each one loads its whole effective frame first, then mixes
		// fetches with reloads and noise; the second and third use the widest and
		// tallest frames
		while (items_sent < ITEM_TARGET) begin
			case (settings_count % 64)
				4: begin
					sw_raw = 255;
					sh_raw = 1;
					nc_raw = 1;
				end
				5: begin
					sw_raw = 0;
					sh_raw = 128;
					nc_raw = 0;
				end
				default: begin
					sw_raw = $urandom_range(0, 6);
					sh_raw = $urandom_range(0, 6);
					nc_raw = $urandom_range(0, 7);
				end
			endcase
			program_frame(sw_raw, sh_raw, nc_raw, random_out_size(), random_out_size());

			for (int y = 0; y < eff_sh; y++)
				for (int x = 0; x < eff_sw; x++)
					for (int c = 0; c < eff_nc; c++)
						offer_item(KIND_LOAD, x, y, c, $urandom);

			// now and then the receiver freezes while fetches keep coming
			if (settings_count % 4 == 3)
				long_hold_req = 1'b1;

			body_items = $urandom_range(30, 80);
			for (int n = 0; n < body_items; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 10)
					offer_item(KIND_LOAD, $urandom_range(0, eff_sw - 1),
						$urandom_range(0, eff_sh - 1), $urandom_range(0, eff_nc - 1), $urandom);
				else if (pick < 16)
					offer_item(KIND_LOAD, $urandom, $urandom, $urandom, $urandom);
				else if (pick < 84)
					offer_item(KIND_FETCH, $urandom_range(0, out_w - 1),
						$urandom_range(0, out_h - 1), $urandom_range(0, eff_nc - 1), $urandom);
				else
					// mostly out of frame on some axis, fields random over their full width
					offer_item(KIND_FETCH,
						$urandom_range(0, 1) ? $urandom : $urandom_range(0, out_w - 1),
						$urandom_range(0, 1) ? $urandom : $urandom_range(0, out_h - 1),
						$urandom, $urandom);
			end
			settle();
		end

		$display("covered %0d register settings: %0d loads, %0d fetches (%0d outside the frame)",
			settings_count, loads_seen, fetches_seen, bad_seen);
		$display("with bursty input, varied output stalls and %0d-cycle output hold-offs",
			LONG_HOLD);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
